@@ rtl/ppsch_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsch_pkg
// Shared types, codes and helpers of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package ppsch_pkg;

  // default table depth
  localparam int MAX_TASKS_DEF = 16;

  // field limits
  localparam logic [15:0] WAIT_MAX  = 16'hFFFF;
  localparam logic [15:0] TIME_MAX  = 16'hFFFF;
  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [4:0]  DONE_MAX  = 5'd31;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // status codes
  localparam logic [1:0] STAT_RAN    = 2'd0;
  localparam logic [1:0] STAT_IDLE   = 2'd1;
  localparam logic [1:0] STAT_LOADED = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  // one table entry as stored in the task memory
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [15:0] wait_cnt;
  } task_rec_t;

  // memory access strobes from the controller
  typedef struct packed {
    logic rd_en;
    logic we;
  } mem_ctl_t;

  // a task is ready once it has arrived and still has service left
  function automatic logic task_ready(input task_rec_t rec, input logic [15:0] now);
    task_ready = (rec.arrival <= now) && (rec.remaining != 16'd0);
  endfunction

endpackage

@@ rtl/ppsch_ifs.sv @@
// ----------------------------------------------------------------------------
// ppsch_ifs
// Valid/ready channels of the scheduler: request items and result items.
// ----------------------------------------------------------------------------
interface ppsch_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] task_id;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic [7:0]  priority_req;

  modport source (output valid, output action, output task_id, output arrival_time,
                  output burst_length, output priority_req, input ready);
  modport sink (input valid, input action, input task_id, input arrival_time,
                input burst_length, input priority_req, output ready);
endinterface

interface ppsch_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] run_id;
  logic [15:0] remaining_before;
  logic        finished;
  logic [15:0] finished_wait;
  logic [19:0] total_wait;
  logic [4:0]  completed_count;
  logic [15:0] current_time;

  modport source (output valid, output status, output run_id, output remaining_before,
                  output finished, output finished_wait, output total_wait,
                  output completed_count, output current_time, input ready);
  modport sink (input valid, input status, input run_id, input remaining_before,
                input finished, input finished_wait, input total_wait,
                input completed_count, input current_time, output ready);
endinterface

@@ rtl/ppsch_table.sv @@
// ----------------------------------------------------------------------------
// ppsch_table
// Task table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppsch_table
  import ppsch_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int IW        = $clog2(MAX_TASKS)
) (
  input  logic            clk,
  input  mem_ctl_t        ctl,
  input  logic [IW-1:0]   rd_addr,
  input  logic [IW-1:0]   wr_addr,
  input  task_rec_t       wr_data,
  output task_rec_t       rd_data
);

  task_rec_t mem [0:MAX_TASKS-1];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ppsch_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppsch_ctrl
// Scheduler sequencer: load, selection scan, wait update pass, result register.
// ----------------------------------------------------------------------------
module ppsch_ctrl
  import ppsch_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int IW        = $clog2(MAX_TASKS),
  parameter int CW        = $clog2(MAX_TASKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  ppsch_in_if.sink          in_ch,
  ppsch_out_if.source       out_ch,
  output mem_ctl_t          mem_ctl,
  output logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     wr_addr,
  output task_rec_t         wr_data,
  input  task_rec_t         rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_PASS2 = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

  logic [2:0]    state;
  logic [CW-1:0] entry_count;
  logic [15:0]   time_now;
  logic [19:0]   wait_sum;
  logic [4:0]    done_count;
  logic [CW-1:0] issue_idx;
  logic          eval_vld;
  logic [IW-1:0] eval_idx;
  logic          found;
  logic [IW-1:0] pick;
  task_rec_t     best;

  logic [1:0]    res_status;
  logic [15:0]   res_run_id;
  logic [15:0]   res_rem;
  logic          res_fin;
  logic [15:0]   res_fwait;
  logic [15:0]   res_time;

  logic          in_fire;
  logic          issue_active;
  logic          scan_done;
  logic          out_free;
  logic          eval_ready;
  logic [20:0]   sum_wide;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign issue_active = (issue_idx < entry_count);
  assign scan_done    = !issue_active && !eval_vld;
  assign out_free     = !out_ch.valid || out_ch.ready;
  assign eval_ready   = task_ready(rd_data, time_now);
  assign sum_wide     = {1'b0, wait_sum} + {5'd0, best.wait_cnt};

  // memory access selection
  always_comb begin
    mem_ctl.rd_en = 1'b0;
    mem_ctl.we    = 1'b0;
    rd_addr       = issue_idx[IW-1:0];
    wr_addr       = pick;
    wr_data       = best;
    case (state)
      S_IDLE: begin
        if (in_fire && in_ch.action == ACT_LOAD && entry_count < CNT_MAX) begin
          mem_ctl.we         = 1'b1;
          wr_addr            = entry_count[IW-1:0];
          wr_data.id         = in_ch.task_id;
          wr_data.arrival    = in_ch.arrival_time;
          wr_data.remaining  = in_ch.burst_length;
          wr_data.prio       = in_ch.priority_req;
          wr_data.wait_cnt   = 16'd0;
        end
      end
      S_SCAN: begin
        mem_ctl.rd_en = issue_active;
      end
      S_UPD: begin
        mem_ctl.we        = 1'b1;
        wr_data.remaining = best.remaining - 16'd1;
      end
      S_PASS2: begin
        mem_ctl.rd_en = issue_active;
        // bump the wait of every other ready task, saturating at WAIT_MAX
        if (eval_vld && eval_idx != pick && eval_ready && rd_data.wait_cnt != WAIT_MAX) begin
          mem_ctl.we       = 1'b1;
          wr_addr          = eval_idx;
          wr_data          = rd_data;
          wr_data.wait_cnt = rd_data.wait_cnt + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      time_now     <= 16'd0;
      wait_sum     <= 20'd0;
      done_count   <= 5'd0;
      issue_idx    <= '0;
      eval_vld     <= 1'b0;
      found        <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_RES) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            issue_idx <= '0;
            eval_vld  <= 1'b0;
            found     <= 1'b0;
            if (in_ch.action == ACT_LOAD) begin
              if (entry_count < CNT_MAX) begin
                entry_count <= entry_count + CW'(1);
              end
              state <= S_RES;
            end else if (entry_count == '0) begin
              state <= S_RES;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue_active) begin
            issue_idx <= issue_idx + CW'(1);
          end
          eval_vld <= issue_active;
          if (eval_vld && eval_ready && (!found || rd_data.prio < best.prio)) begin
            found <= 1'b1;
          end
          if (scan_done) begin
            state <= found ? S_UPD : S_RES;
          end
        end
        S_UPD: begin
          issue_idx <= '0;
          eval_vld  <= 1'b0;
          if (best.remaining != 16'd1) begin
            state <= S_PASS2;
          end else begin
            // task completes on this tick
            wait_sum <= sum_wide[20] ? TOTAL_MAX : sum_wide[19:0];
            if (done_count != DONE_MAX) begin
              done_count <= done_count + 5'd1;
            end
            if (time_now != TIME_MAX) begin
              time_now <= time_now + 16'd1;
            end
            state <= S_RES;
          end
        end
        S_PASS2: begin
          if (issue_active) begin
            issue_idx <= issue_idx + CW'(1);
          end
          eval_vld <= issue_active;
          if (scan_done) begin
            if (time_now != TIME_MAX) begin
              time_now <= time_now + 16'd1;
            end
            state <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    eval_idx <= issue_idx[IW-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_time   <= time_now;
          res_run_id <= 16'd0;
          res_rem    <= 16'd0;
          res_fin    <= 1'b0;
          res_fwait  <= 16'd0;
          if (in_ch.action == ACT_LOAD) begin
            res_status <= (entry_count < CNT_MAX) ? STAT_LOADED : STAT_FULL;
          end else begin
            res_status <= STAT_IDLE;
          end
        end
      end
      S_SCAN: begin
        // strict compare keeps the earliest loaded task on a tie
        if (eval_vld && eval_ready && (!found || rd_data.prio < best.prio)) begin
          pick <= eval_idx;
          best <= rd_data;
        end
      end
      S_UPD: begin
        res_status <= STAT_RAN;
        res_run_id <= best.id;
        res_rem    <= best.remaining;
        if (best.remaining == 16'd1) begin
          res_fin   <= 1'b1;
          res_fwait <= best.wait_cnt;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_ch.status           <= res_status;
          out_ch.run_id           <= res_run_id;
          out_ch.remaining_before <= res_rem;
          out_ch.finished         <= res_fin;
          out_ch.finished_wait    <= res_fwait;
          out_ch.total_wait       <= wait_sum;
          out_ch.completed_count  <= done_count;
          out_ch.current_time     <= res_time;
        end
      end
      default: begin
      end
    endcase
  end

  // table fill never passes the depth
  assert property (@(posedge clk) disable iff (rst) entry_count <= CNT_MAX)
    else $error("entry count beyond table depth");

  // no table write while the selection scan runs
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> !mem_ctl.we)
    else $error("table write during selection scan");

  // the wait pass never touches the running task
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS2 && mem_ctl.we) |-> wr_addr != pick)
    else $error("wait pass wrote the running task");

  // only written entries are evaluated
  assert property (@(posedge clk) disable iff (rst)
    eval_vld |-> CW'(eval_idx) < entry_count)
    else $error("evaluated an entry beyond the fill count");

  // an accepted request blocks the next one until its result is built
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ch.ready)
    else $error("request accepted while busy");

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Task table with lowest-priority-value selection, wait and time accounting.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch. A load transaction (action 0) stores one
// task in the next free table entry and returns status 2, or 3 when the table
// is full. A tick transaction (action 1) scans the table, runs the ready task
// with the lowest priority value (earliest loaded on a tie) and returns one
// result on out_ch with run id, remaining time, completion flag and totals.
// Every request gives exactly one result transaction.
// Request flow: a load or an empty-table tick goes straight to the result
// state. A tick scans the table, updates the run task (skipped when no task
// is ready) and then loads the result; when the run task does not finish, a
// wait update pass over the table comes before the result. The scan and the
// pass use the table memory's single read port, one entry per cycle. One
// request is in work at a time; the next is accepted after the result loads.
// Reset clears the fill count, time, wait total and completion count; table
// contents are only read below the fill count, so no clearing is done.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and worked, then waits for the register to free.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import ppsch_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input logic          clk,
  input logic          rst,
  ppsch_in_if.sink     in_ch,
  ppsch_out_if.source  out_ch
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  mem_ctl_t      mem_ctl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  task_rec_t     wr_data;
  task_rec_t     rd_data;

  // sequencer
  ppsch_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // task table
  ppsch_table #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority scheduler. Directed tests
// cover the empty table, tasks that never become ready, priority ties and
// preemption, and the full table; a long random mix of loads and ticks runs
// ahead of the full table test. Every accepted request updates a local
// scheduler predictor and every result transaction is compared field by
// field against it, with random gaps on requests and random stalls on results.
// ----------------------------------------------------------------------------
module tb
  import ppsch_pkg::*;
;

  localparam int TBL_DEPTH   = MAX_TASKS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_CAP   = 200;

  typedef struct {
    logic        action;
    logic [15:0] task_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } sched_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] run_id;
    logic [15:0] remaining_before;
    logic        finished;
    logic [15:0] finished_wait;
    logic [19:0] total_wait;
    logic [4:0]  completed_count;
    logic [15:0] current_time;
  } sched_result_t;

  logic clk;
  logic rst;

  ppsch_in_if  in_ch ();
  ppsch_out_if out_ch ();

  preemptive_priority_scheduler u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted scheduler state
  logic [15:0] tq_id   [TBL_DEPTH];
  logic [15:0] tq_arr  [TBL_DEPTH];
  logic [15:0] tq_left [TBL_DEPTH];
  logic [7:0]  tq_prio [TBL_DEPTH];
  logic [15:0] tq_wait [TBL_DEPTH];
  int          tbl_fill;
  int          sched_time;
  int          wait_total;
  int          done_total;

  sched_result_t pending_results[$];

  int err_count;
  int cycle_count;
  int stall_left;
  bit steady_flow;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [19:0] got,
                             input logic [19:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // one scheduler step of the predictor: updates state and queues the result
  function automatic void schedule_step(input sched_req_t req);
    int k;
    int pick;
    bit found;
    sched_result_t r;
    r.status           = STAT_LOADED;
    r.run_id           = '0;
    r.remaining_before = '0;
    r.finished         = 1'b0;
    r.finished_wait    = '0;
    r.current_time     = sched_time[15:0];
    pick  = 0;
    found = 1'b0;
    if (req.action == ACT_LOAD) begin
      if (tbl_fill >= TBL_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        tq_id[tbl_fill]   = req.task_id;
        tq_arr[tbl_fill]  = req.arrival;
        tq_left[tbl_fill] = req.burst;
        tq_prio[tbl_fill] = req.prio;
        tq_wait[tbl_fill] = '0;
        tbl_fill++;
        r.status = STAT_LOADED;
      end
    end else begin
      // lowest priority value among ready tasks, earliest loaded on a tie
      for (k = 0; k < tbl_fill; k++) begin
        if (tq_arr[k] <= sched_time && tq_left[k] != 0 &&
            (!found || tq_prio[k] < tq_prio[pick])) begin
          pick  = k;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = STAT_IDLE;
      end else begin
        r.status           = STAT_RAN;
        r.run_id           = tq_id[pick];
        r.remaining_before = tq_left[pick];
        tq_left[pick]      = tq_left[pick] - 16'd1;
        if (tq_left[pick] != 0) begin
          // the others that were ready keep waiting
          for (k = 0; k < tbl_fill; k++) begin
            if (k != pick && tq_arr[k] <= sched_time && tq_left[k] != 0 &&
                tq_wait[k] != WAIT_MAX)
              tq_wait[k] = tq_wait[k] + 16'd1;
          end
        end else begin
          r.finished      = 1'b1;
          r.finished_wait = tq_wait[pick];
          wait_total      = wait_total + int'(tq_wait[pick]);
          if (wait_total > TOTAL_MAX) wait_total = int'(TOTAL_MAX);
          if (done_total < DONE_MAX) done_total++;
        end
        if (sched_time < TIME_MAX) sched_time++;
      end
    end
    r.total_wait      = wait_total[19:0];
    r.completed_count = done_total[4:0];
    pending_results.push_back(r);
  endfunction

  // send one request transaction and predict its result
  task automatic send_request(input logic act, input logic [15:0] id,
                              input logic [15:0] arr, input logic [15:0] burst,
                              input logic [7:0] prio);
    int gap;
    sched_req_t req;
    gap = steady_flow ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.task_id      <= id;
    in_ch.arrival_time <= arr;
    in_ch.burst_length <= burst;
    in_ch.priority_req <= prio;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    req.action  = act;
    req.task_id = id;
    req.arrival = arr;
    req.burst   = burst;
    req.prio    = prio;
    schedule_step(req);
  endtask

  // a tick carries random payload, which the block ignores
  task automatic send_tick();
    send_request(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // a task that arrives soon, with a short random burst
  task automatic load_soon_task();
    int arr;
    logic [15:0] burst;
    logic [7:0] prio;
    arr = sched_time + $urandom_range(0, 15);
    if (arr > TIME_MAX) arr = int'(TIME_MAX);
    burst = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 180));
    prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    send_request(ACT_LOAD, 16'($urandom), arr[15:0], burst, prio);
  endtask

  // result checker and random stall on the result side
  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_error("result transaction with no request waiting");
        end else begin
          want = pending_results.pop_front();
          check_field("status", 20'(out_ch.status), 20'(want.status));
          check_field("run_id", 20'(out_ch.run_id), 20'(want.run_id));
          check_field("remaining_before", 20'(out_ch.remaining_before),
                      20'(want.remaining_before));
          check_field("finished", 20'(out_ch.finished), 20'(want.finished));
          check_field("finished_wait", 20'(out_ch.finished_wait),
                      20'(want.finished_wait));
          check_field("total_wait", out_ch.total_wait, want.total_wait);
          check_field("completed_count", 20'(out_ch.completed_count),
                      20'(want.completed_count));
          check_field("current_time", 20'(out_ch.current_time),
                      20'(want.current_time));
        end
        stall_left = steady_flow ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // tick with nothing loaded
  task automatic test_empty_table();
    send_tick();
    send_tick();
  endtask

  // far arrival and zero burst: stored but never ready
  task automatic test_never_ready();
    send_request(ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
    send_request(ACT_LOAD, 16'h0000, 16'h0000, 16'h0000, 8'd0);
    send_tick();
  endtask

  // equal priorities go in load order, a lower value preempts on arrival
  task automatic test_priority_ties();
    send_request(ACT_LOAD, 16'h1234, 16'h0000, 16'd3, 8'd255);
    send_request(ACT_LOAD, 16'h00A5, 16'h0000, 16'd2, 8'd255);
    send_request(ACT_LOAD, 16'h5A5A, 16'h0002, 16'd1, 8'd7);
    repeat (8) send_tick();
  endtask

  // mostly ticks, tasks loaded through the run, status-3 loads once full
  task automatic test_random_mix();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      if (tbl_fill < TBL_DEPTH && (n % 125 == 0 || $urandom_range(0, 59) == 0))
        load_soon_task();
      else if (tbl_fill >= TBL_DEPTH && $urandom_range(0, 19) == 0)
        send_request(ACT_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      else
        send_tick();
    end
    steady_flow = 1'b0;
  endtask

  // loads into a full table change nothing
  task automatic test_full_table();
    while (tbl_fill < TBL_DEPTH) load_soon_task();
    send_request(ACT_LOAD, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (3) send_request(ACT_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom));
    repeat (20) send_tick();
  endtask

  // main sequence
  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_LOAD;
    in_ch.task_id      = '0;
    in_ch.arrival_time = '0;
    in_ch.burst_length = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    tbl_fill    = 0;
    sched_time  = 0;
    wait_total  = 0;
    done_total  = 0;
    err_count   = 0;
    cycle_count = 0;
    steady_flow = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_never_ready();
    test_priority_ties();
    test_random_mix();
    test_full_table();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
